// ----- hw/rtl/cbba_pkg.sv -----
`default_nettype none

package cbba_pkg;

  // Coordinate and register widths.
  localparam int COORD_BITS    = 12;
  localparam int DX_BITS       = COORD_BITS + 2;
  localparam int SCREEN_BITS   = 13;
  localparam int SCAN_BITS     = 15;
  localparam int DEPTH_BITS    = 6;
  localparam int BPP_BITS      = 4;
  localparam int ADDR_BITS     = 27;
  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int OUT_DEPTH     = 2;

  // Command codes of an input word.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCANLINE_BYTES = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_DEPTH    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEXT_MODE      = 3'd4;

  // Register reset values.
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_WIDTH   = 13'd320;
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_HEIGHT  = 13'd200;
  localparam logic [SCAN_BITS-1:0]   RST_SCANLINE_BYTES = 15'd320;
  localparam logic [DEPTH_BITS-1:0]  RST_COLOR_DEPTH    = 6'd8;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic [COORD_BITS-1:0]        rect_width;
    logic [COORD_BITS-1:0]        rect_height;
    logic [7:0]                   red_in;
    logic [7:0]                   green_in;
    logic [7:0]                   blue_in;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] write_address;
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;
    logic                 clipped;
    logic                 last;
  } out_word_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic [SCREEN_BITS-1:0] dx;
    logic [SCREEN_BITS-1:0] dy;
    logic                   clipped;
    logic                   last;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
  } job_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_width;
    logic [SCREEN_BITS-1:0] screen_height;
    logic [SCAN_BITS-1:0]   scanline_bytes;
    logic [DEPTH_BITS-1:0]  color_depth;
    logic                   text_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clipped_rectangle_blit_addresser_top.sv -----
// Clipped rectangle blit addresser. A start word opens a rectangle with a signed origin
// and a size; the pixel words that follow, in row-major order, each give one result word
// with the framebuffer byte address, the color bytes, a clipped flag and a last flag.
// Pixels with no rectangle open, start words, and every word in text mode give no result.
// The block takes one word per clock while full is low and gives one result per clock
// while the output side keeps popping. A result is written into the job queue and then
// into the result queue before it reaches the output ports. The front classifies words
// and feeds a job queue of QUEUE_DEPTH entries; full rises only when that queue is full,
// which happens when the output side stops popping. The back computes the address with
// a row multiply and a small column multiply and writes a two-entry result queue.
// Configuration is written through the cfg channel, which is always ready, and must be
// written only while the block is idle.
`default_nettype none

module clipped_rectangle_blit_addresser_top
  import cbba_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire in_word_t                in_word_i,
  input  wire logic                    pop,
  output logic                         empty,
  output out_word_t                    out_word_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [SCAN_BITS-1:0]    cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      accept;
  logic      job_push, job_pop, job_full, job_empty;
  job_t      job_in, job_out;
  logic      out_push, out_full;
  out_word_t out_in;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:   cfg_d.screen_width   = cfg_data_i[SCREEN_BITS-1:0];
        CFG_SCREEN_HEIGHT:  cfg_d.screen_height  = cfg_data_i[SCREEN_BITS-1:0];
        CFG_SCANLINE_BYTES: cfg_d.scanline_bytes = cfg_data_i;
        CFG_COLOR_DEPTH:    cfg_d.color_depth    = cfg_data_i[DEPTH_BITS-1:0];
        CFG_TEXT_MODE:      cfg_d.text_mode      = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width   <= RST_SCREEN_WIDTH;
      cfg_q.screen_height  <= RST_SCREEN_HEIGHT;
      cfg_q.scanline_bytes <= RST_SCANLINE_BYTES;
      cfg_q.color_depth    <= RST_COLOR_DEPTH;
      cfg_q.text_mode      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input side.
  assign full   = job_full;
  assign accept = push && !full;

  cbba_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .word_i     (in_word_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Job queue between front and back.
  cbba_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  cbba_back u_back (
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (out_in)
  );

  // Result queue on the output side.
  cbba_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_word_o),
    .empty_o (empty)
  );

  // Text mode must keep every word out of the job queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_q.text_mode |-> !job_push)
    else $error("job queued while text mode is set");

  // A clipped result always carries a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.clipped) |-> (out_word_o.write_address == '0))
    else $error("clipped result with nonzero address");

  // The back only moves a job that exists into a result queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> (!job_empty && !out_full))
    else $error("job moved without data or room");

  // A job never enters a full queue, since full holds off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("job pushed into full queue");

endmodule

`default_nettype wire

// ----- hw/rtl/cbba_fifo.sv -----
`default_nettype none

module cbba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cbba_front.sv -----
`default_nettype none

module cbba_front
  import cbba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     accept_i,
  input  wire in_word_t word_i,
  output logic          job_push_o,
  output job_t          job_o
);

  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic [COORD_BITS-1:0] span_w_q, span_w_d, span_h_q, span_h_d;
  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;

  logic signed [DX_BITS-1:0] dx, dy;
  logic [COORD_BITS:0]       col_inc, row_inc;
  logic                      col_wrap, row_wrap, fin, clip, is_pixel;

  // Screen coordinates of the current pixel.
  assign dx = DX_BITS'(signed'(base_x_q)) + DX_BITS'(col_q);
  assign dy = DX_BITS'(signed'(base_y_q)) + DX_BITS'(row_q);

  // Negative coordinates are off screen, as are ones past the visible area.
  assign clip = dx[DX_BITS-1] || dy[DX_BITS-1] ||
                (dx[SCREEN_BITS-1:0] >= cfg_i.screen_width) ||
                (dy[SCREEN_BITS-1:0] >= cfg_i.screen_height);

  // End of row and end of rectangle detection.
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign col_wrap = col_inc >= {1'b0, span_w_q};
  assign row_wrap = row_inc >= {1'b0, span_h_q};
  assign fin      = col_wrap && row_wrap;

  assign is_pixel   = accept_i && !cfg_i.text_mode && (word_i.cmd == CMD_PIXEL);
  assign job_push_o = is_pixel && active_q;

  always_comb begin
    job_o.dx      = dx[SCREEN_BITS-1:0];
    job_o.dy      = dy[SCREEN_BITS-1:0];
    job_o.clipped = clip;
    job_o.last    = fin;
    job_o.red     = word_i.red_in;
    job_o.green   = word_i.green_in;
    job_o.blue    = word_i.blue_in;
  end

  // Rectangle state: start words load it, pixels step the counters.
  always_comb begin
    active_d = active_q;
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    span_w_d = span_w_q;
    span_h_d = span_h_q;
    col_d    = col_q;
    row_d    = row_q;
    if (accept_i && !cfg_i.text_mode && (word_i.cmd == CMD_START)) begin
      base_x_d = word_i.origin_x;
      base_y_d = word_i.origin_y;
      span_w_d = word_i.rect_width;
      span_h_d = word_i.rect_height;
      col_d    = '0;
      row_d    = '0;
      active_d = (word_i.rect_width != '0) && (word_i.rect_height != '0);
    end else if (job_push_o) begin
      if (fin) begin
        active_d = 1'b0;
        col_d    = '0;
        row_d    = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_inc[COORD_BITS-1:0];
      end else begin
        col_d = col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      base_x_q <= '0;
      base_y_q <= '0;
      span_w_q <= '0;
      span_h_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      active_q <= active_d;
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      span_w_q <= span_w_d;
      span_h_q <= span_h_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cbba_back.sv -----
`default_nettype none

module cbba_back
  import cbba_pkg::*;
(
  input  wire cfg_t  cfg_i,
  input  wire job_t  job_i,
  input  wire logic  job_empty_i,
  output logic       job_pop_o,
  input  wire logic  out_full_i,
  output logic       out_push_o,
  output out_word_t  out_word_o
);

  localparam int PROD_BITS = SCREEN_BITS + SCAN_BITS;

  logic [DEPTH_BITS:0]           depth_inc;
  logic [BPP_BITS-1:0]           bpp;
  logic [PROD_BITS-1:0]          row_offset;
  logic [SCREEN_BITS+BPP_BITS-1:0] col_offset;
  logic [PROD_BITS:0]            addr_full;

  // Move one job whenever there is one and the result queue has room.
  assign job_pop_o  = !job_empty_i && !out_full_i;
  assign out_push_o = job_pop_o;

  // Bytes per pixel is (depth + 1) / 8.
  assign depth_inc = {1'b0, cfg_i.color_depth} + 1'b1;
  assign bpp       = depth_inc[DEPTH_BITS:3];

  // Framebuffer byte address: row times scanline plus column times bytes per pixel.
  assign row_offset = PROD_BITS'(job_i.dy) * PROD_BITS'(cfg_i.scanline_bytes);
  assign col_offset = (SCREEN_BITS + BPP_BITS)'(job_i.dx) *
                      (SCREEN_BITS + BPP_BITS)'(bpp);
  assign addr_full  = (PROD_BITS + 1)'(row_offset) + (PROD_BITS + 1)'(col_offset);

  always_comb begin
    out_word_o.write_address = job_i.clipped ? '0 : addr_full[ADDR_BITS-1:0];
    out_word_o.red_out       = job_i.red;
    out_word_o.green_out     = job_i.green;
    out_word_o.blue_out      = job_i.blue;
    out_word_o.clipped       = job_i.clipped;
    out_word_o.last          = job_i.last;
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_clipped_rectangle_blit_addresser_top.sv -----
`timescale 1ns / 1ps

module tb_clipped_rectangle_blit_addresser_top;
  import cbba_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES      = 8;

  // Tracks the rectangle walk and the registers, and predicts one result word per pixel.
  class blit_tracker;
    cfg_t                         regs;
    bit                           rect_open;
    logic signed [COORD_BITS-1:0] org_x;
    logic signed [COORD_BITS-1:0] org_y;
    logic [COORD_BITS-1:0]        span_w;
    logic [COORD_BITS-1:0]        span_h;
    logic [COORD_BITS-1:0]        col;
    logic [COORD_BITS-1:0]        row;
    out_word_t                    pending_pixels[$];
    int                           errors;
    int                           words_taken;
    int                           pixels_checked;
    int                           clipped_seen;
    int                           rects_finished;

    function new();
      regs = '{RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_SCANLINE_BYTES, RST_COLOR_DEPTH, 1'b0};
      rect_open = 1'b0;
      org_x = '0;
      org_y = '0;
      span_w = '0;
      span_h = '0;
      col = '0;
      row = '0;
      errors = 0;
      words_taken = 0;
      pixels_checked = 0;
      clipped_seen = 0;
      rects_finished = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SCAN_BITS-1:0] data);
      case (idx)
        CFG_SCREEN_WIDTH:   regs.screen_width = data[SCREEN_BITS-1:0];
        CFG_SCREEN_HEIGHT:  regs.screen_height = data[SCREEN_BITS-1:0];
        CFG_SCANLINE_BYTES: regs.scanline_bytes = data;
        CFG_COLOR_DEPTH:    regs.color_depth = data[DEPTH_BITS-1:0];
        CFG_TEXT_MODE:      regs.text_mode = data[0];
        default: ;
      endcase
    endfunction

    // Start words load the rectangle; pixel words advance the walk and yield a result.
    function void take_word(in_word_t w);
      int        bx, by, col_i, row_i, dx, dy, bpp;
      bit        off_screen, is_last;
      longint    addr;
      out_word_t exp_word;
      words_taken++;
      if (regs.text_mode) return;
      if (w.cmd == CMD_START) begin
        org_x = w.origin_x;
        org_y = w.origin_y;
        span_w = w.rect_width;
        span_h = w.rect_height;
        col = '0;
        row = '0;
        rect_open = (span_w != 0) && (span_h != 0);
        return;
      end
      if (!rect_open) return;
      bx = org_x;
      by = org_y;
      col_i = col;
      row_i = row;
      dx = bx + col_i;
      dy = by + row_i;
      off_screen = dx < 0 || dy < 0 || dx >= int'(regs.screen_width) ||
                   dy >= int'(regs.screen_height);
      addr = 0;
      if (!off_screen) begin
        bpp = (int'(regs.color_depth) + 1) / BITS_PER_BYTE;
        addr = longint'(dy) * longint'(regs.scanline_bytes) + longint'(dx) * longint'(bpp);
      end
      is_last = (col_i + 1 >= int'(span_w)) && (row_i + 1 >= int'(span_h));
      if (col_i + 1 >= int'(span_w)) begin
        col = '0;
        row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
      if (is_last) begin
        rect_open = 1'b0;
        col = '0;
        row = '0;
      end
      exp_word.write_address = ADDR_BITS'(addr);
      exp_word.red_out = w.red_in;
      exp_word.green_out = w.green_in;
      exp_word.blue_out = w.blue_in;
      exp_word.clipped = off_screen;
      exp_word.last = is_last;
      pending_pixels.push_back(exp_word);
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_pixels.size() == 0) begin
        $error("result word with no pixel waiting: %p", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (want.clipped) clipped_seen++;
      if (want.last) rects_finished++;
      match_field("write_address", 64'(want.write_address), 64'(got.write_address));
      match_field("red_out", 64'(want.red_out), 64'(got.red_out));
      match_field("green_out", 64'(want.green_out), 64'(got.green_out));
      match_field("blue_out", 64'(want.blue_out), 64'(got.blue_out));
      match_field("clipped", 64'(want.clipped), 64'(got.clipped));
      match_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  in_word_t                in_word_i;
  logic                    pop;
  logic                    empty;
  out_word_t               out_word_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [SCAN_BITS-1:0]    cfg_data_i;

  blit_tracker board;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_left;
  bit          hold_wanted;
  int          sent_words;
  int          settings_used;

  clipped_rectangle_blit_addresser_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .pop         (pop),
    .empty       (empty),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver pops at random, except during a requested hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // A hold-off request is picked up at the rising edge and counted down above.
  always @(posedge clk_i) begin
    if (hold_wanted) begin
      hold_wanted = 1'b0;
      hold_left = HOLD_CYCLES;
    end
  end

  // Every handshake is observed at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.take_word(in_word_i);
      if (pop && !empty) board.check_result(out_word_o);
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("** clipped_rectangle_blit_addresser_top: FAILED **");
    $finish;
  end

  function automatic in_word_t rand_word();
    in_word_t w;
    w.cmd = 1'($urandom);
    w.origin_x = COORD_BITS'($urandom);
    w.origin_y = COORD_BITS'($urandom);
    w.rect_width = COORD_BITS'($urandom);
    w.rect_height = COORD_BITS'($urandom);
    w.red_in = 8'($urandom);
    w.green_in = 8'($urandom);
    w.blue_in = 8'($urandom);
    return w;
  endfunction

  // Fields a word does not use still carry random content.
  function automatic in_word_t start_word(int ox, int oy, int rw, int rh);
    in_word_t w;
    w = rand_word();
    w.cmd = CMD_START;
    w.origin_x = COORD_BITS'(ox);
    w.origin_y = COORD_BITS'(oy);
    w.rect_width = COORD_BITS'(rw);
    w.rect_height = COORD_BITS'(rh);
    return w;
  endfunction

  function automatic in_word_t pixel_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_word_t w;
    w = rand_word();
    w.cmd = CMD_PIXEL;
    w.red_in = r;
    w.green_in = g;
    w.blue_in = b;
    return w;
  endfunction

  function automatic in_word_t rand_pixel();
    return pixel_word(8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Origins cluster around both screen edges so that clipping is frequent.
  function automatic int pick_origin(int screen, int extent);
    int v;
    case ($urandom_range(2))
      0:       v = int'($urandom_range(16)) - 8;
      1:       v = screen - int'($urandom_range(extent + 4));
      default: v = int'($urandom_range(4095)) - 2048;
    endcase
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v;
  endfunction

  // Offers one word, idling first at random, and returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    sent_words++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [SCAN_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t c);
    cfg_write(CFG_SCREEN_WIDTH, SCAN_BITS'(c.screen_width));
    cfg_write(CFG_SCREEN_HEIGHT, SCAN_BITS'(c.screen_height));
    cfg_write(CFG_SCANLINE_BYTES, c.scanline_bytes);
    cfg_write(CFG_COLOR_DEPTH, SCAN_BITS'(c.color_depth));
    cfg_write(CFG_TEXT_MODE, SCAN_BITS'(c.text_mode));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Stops offering words, waits for every expected result, then lets the pipeline settle.
  task automatic drain();
    push <= 1'b0;
    while (board.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One rectangle: mostly small and complete, sometimes empty, huge or cut short.
  task automatic blit_random_rect(input cfg_t c);
    int kind, rw, rh, npix;
    kind = $urandom_range(99);
    if (kind < 82) begin
      rw = $urandom_range(1, 8);
      rh = $urandom_range(1, 6);
    end else if (kind < 88) begin
      if ($urandom_range(1) == 1) begin
        rw = 0;
        rh = $urandom_range(4095);
      end else begin
        rw = $urandom_range(4095);
        rh = 0;
      end
    end else begin
      rw = $urandom_range(4095);
      rh = $urandom_range(4095);
    end
    npix = rw * rh;
    if (npix == 0) npix = $urandom_range(2);
    else if (npix > 48 || $urandom_range(99) < 10) npix = $urandom_range(npix > 24 ? 24 : npix);
    send_word(start_word(pick_origin(int'(c.screen_width), rw),
                         pick_origin(int'(c.screen_height), rh), rw, rh));
    repeat (npix) send_word(rand_pixel());
    if ($urandom_range(99) < 6) repeat ($urandom_range(1, 2)) send_word(rand_pixel());
  endtask

  initial begin : main
    cfg_t phase_cfg [NUM_PHASES];
    int   first_word;
    board = new();
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_wanted = 1'b0;
    sent_words = 0;
    settings_used = 1;

    phase_cfg[0] = '{13'd4096, 13'd4096, 15'd16384, 6'd32, 1'b0};
    phase_cfg[1] = '{13'd1, 13'd1, 15'd1, 6'd1, 1'b0};
    phase_cfg[2] = '{13'd40, 13'd30, 15'd160, 6'd24, 1'b0};
    phase_cfg[3] = '{13'd0, 13'd25, 15'd100, 6'd16, 1'b0};
    phase_cfg[4] = '{13'd64, 13'd48, 15'd64, 6'd0, 1'b0};
    phase_cfg[5] = '{13'd320, 13'd200, 15'd32767, 6'd63, 1'b0};
    phase_cfg[6] = '{13'd50, 13'd40, 15'd200, 6'd8, 1'b1};
    phase_cfg[7] = '{13'd640, 13'd480, 15'd2560, 6'd32, 1'b0};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words at the reset settings.
    // A pixel with no rectangle open is dropped.
    send_word(rand_pixel());
    // Color extremes on a two-pixel row at the origin.
    send_word(start_word(0, 0, 2, 1));
    send_word(pixel_word(8'h00, 8'h00, 8'h00));
    send_word(pixel_word(8'hFF, 8'hFF, 8'hFF));
    // Most negative origin with the largest size, abandoned by the next start word.
    send_word(start_word(-2048, -2048, 4095, 4095));
    send_word(rand_pixel());
    // Most positive origin, far off screen, single pixel.
    send_word(start_word(2047, 2047, 1, 1));
    send_word(rand_pixel());
    // Zero width and zero height open no rectangle.
    send_word(start_word(0, 0, 0, 5));
    send_word(rand_pixel());
    send_word(start_word(0, 0, 5, 0));
    send_word(rand_pixel());
    // Straddles the bottom right corner.
    send_word(start_word(318, 198, 3, 3));
    repeat (9) send_word(rand_pixel());
    // Straddles the top left corner.
    send_word(start_word(-1, -1, 2, 2));
    repeat (4) send_word(rand_pixel());

    // Random rectangles under each setting, cycling through the idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_settings(phase_cfg[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      // Early on, the receiver stops for a long stretch so the block fills and stalls.
      if (p == 0) hold_wanted = 1'b1;
      first_word = sent_words;
      while (sent_words - first_word < ITEMS_PER_PHASE) blit_random_rect(phase_cfg[p]);
    end
    drain();

    $display("Run took %0d words under %0d register settings and checked %0d pixels.",
             board.words_taken, settings_used, board.pixels_checked);
    $display("Of those pixels %0d were clipped and %0d closed a rectangle.",
             board.clipped_seen, board.rects_finished);
    if (board.errors == 0 && board.pending_pixels.size() == 0) begin
      $display("** clipped_rectangle_blit_addresser_top: PASSED **");
    end else begin
      $display("** clipped_rectangle_blit_addresser_top: FAILED **");
    end
    $finish;
  end

endmodule
